>>> rtl/tvn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvn_pkg
// Shared widths, codes, constant tables and status types of the value-noise
// turbulence block.
// ---------------------------------------------------------------------------
package tvn_pkg;

    // Field widths
    localparam int COORD_W = 5;
    localparam int NOISE_W = 15;
    localparam int ZOOM_W  = 8;
    localparam int INT_W   = 8;
    localparam int FRAC_W  = 16;

    // Divider geometry: dividend is (coord * 3^k) << 16, quotient below 32.0
    localparam int DVD_W   = 29;
    localparam int QUO_W   = 21;
    localparam int DCNT_W  = 5;

    // Turbulence accumulator: up to eight Q16 terms below 2^23
    localparam int SUM_W   = 26;

    // Octave tables
    localparam int OCT_TAB   = 8;
    localparam int OCT_IDX_W = 3;
    localparam int POW_W     = 12;
    localparam int RECIP_W   = 25;
    localparam int RECIP_SH  = 24;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Register map (word index bit of the APB address)
    localparam int   APB_AW   = 3;
    localparam int   APB_DW   = 32;
    localparam logic REG_ZOOM = 1'b0;
    localparam logic REG_BASE = 1'b1;

    localparam logic [ZOOM_W-1:0] ZOOM_RST = 8'd3;
    localparam logic [INT_W-1:0]  BASE_RST = 8'd10;
    localparam logic [INT_W-1:0]  INT_MAX  = 8'd255;

    // Powers of three per octave
    localparam logic [POW_W-1:0] POW3 [OCT_TAB] = '{
        12'd1, 12'd3, 12'd9, 12'd27, 12'd81, 12'd243, 12'd729, 12'd2187
    };

    // floor(2^24 / 3^k): reciprocal for the octave weight division
    localparam logic [RECIP_W-1:0] RECIP [OCT_TAB] = '{
        25'd16777216, 25'd5592405, 25'd1864135, 25'd621378,
        25'd207126,   25'd69042,   25'd23014,   25'd7671
    };

    // Core status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
        logic div_busy;
    } t_core_stat;

endpackage
`default_nettype wire

>>> rtl/tvn_stream_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvn_stream_if
// Valid/ready channels: request stream in, pixel result stream out.
// ---------------------------------------------------------------------------
interface tvn_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [tvn_pkg::COORD_W-1:0]  x_coord;
    logic [tvn_pkg::COORD_W-1:0]  y_coord;
    logic [tvn_pkg::NOISE_W-1:0]  noise_value;

    modport source (output valid, req_type, x_coord, y_coord, noise_value, input ready);
    modport sink   (input valid, req_type, x_coord, y_coord, noise_value, output ready);
endinterface

interface tvn_res_if;
    logic                         valid;
    logic                         ready;
    logic [tvn_pkg::INT_W-1:0]    intensity;
    logic [tvn_pkg::COORD_W-1:0]  x_out;
    logic [tvn_pkg::COORD_W-1:0]  y_out;

    modport source (output valid, intensity, x_out, y_out, input ready);
    modport sink   (input valid, intensity, x_out, y_out, output ready);
endinterface
`default_nettype wire

>>> rtl/tvn_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvn_div
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// ---------------------------------------------------------------------------
module tvn_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tvn_pkg::DVD_W-1:0]     i_dvd_x,
    input  wire logic [tvn_pkg::DVD_W-1:0]     i_dvd_y,
    input  wire logic [tvn_pkg::ZOOM_W-1:0]    i_divisor,
    output logic                               o_busy,
    output logic [tvn_pkg::QUO_W-1:0]          o_quo_x,
    output logic [tvn_pkg::QUO_W-1:0]          o_quo_y
);
    localparam int ZW = tvn_pkg::ZOOM_W;
    localparam int QW = tvn_pkg::QUO_W;

    logic [tvn_pkg::DCNT_W-1:0] r_cnt;
    logic [ZW-1:0]              r_div;
    logic [ZW-1:0]              r_rem [2];
    logic [QW-1:0]              r_quo [2];
    logic [ZW-1:0]              n_rem [2];
    logic [QW-1:0]              n_quo [2];

    assign o_busy  = (r_cnt != '0);
    assign o_quo_x = r_quo[0];
    assign o_quo_y = r_quo[1];

    // One restoring step per lane; keep the shifted remainder on a miss
    always_comb begin
        logic [ZW+1:0] trial;
        for (int l = 0; l < 2; l++) begin
            trial = {1'b0, r_rem[l], r_quo[l][QW-1]} - {2'b00, r_div};
            if (!trial[ZW+1]) begin
                n_rem[l] = trial[ZW-1:0];
                n_quo[l] = {r_quo[l][QW-2:0], 1'b1};
            end else begin
                n_rem[l] = {r_rem[l][ZW-2:0], r_quo[l][QW-1]};
                n_quo[l] = {r_quo[l][QW-2:0], 1'b0};
            end
        end
    end

    // Count iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= tvn_pkg::DCNT_W'(QW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Load the dividend's top bits as partial remainder, then shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= i_divisor;
            r_rem[0] <= i_dvd_x[tvn_pkg::DVD_W-1:QW];
            r_quo[0] <= i_dvd_x[QW-1:0];
            r_rem[1] <= i_dvd_y[tvn_pkg::DVD_W-1:QW];
            r_quo[1] <= i_dvd_y[QW-1:0];
        end else if (o_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tvn_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvn_table
// Noise word memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tvn_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [tvn_pkg::NOISE_W-1:0]  i_wdata,
    input  wire logic                         i_re,
    input  wire logic [AW-1:0]                i_raddr,
    output logic [tvn_pkg::NOISE_W-1:0]       o_rdata
);
    logic [tvn_pkg::NOISE_W-1:0] mem [DEPTH];
    logic [tvn_pkg::NOISE_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/tvn_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tvn_core
// Octave sequencer: divides the sample position, reads four neighbors,
// blends them and accumulates the weighted octave terms.
// ---------------------------------------------------------------------------
module tvn_core #(
    parameter int NOISE_WIDTH  = 32,
    parameter int NOISE_HEIGHT = 32,
    parameter int MAX_OCTAVES  = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_req_type,
    input  wire logic [tvn_pkg::COORD_W-1:0]   i_x,
    input  wire logic [tvn_pkg::COORD_W-1:0]   i_y,
    input  wire logic [tvn_pkg::NOISE_W-1:0]   i_noise,
    input  wire logic [tvn_pkg::ZOOM_W-1:0]    i_zoom,
    input  wire logic [tvn_pkg::INT_W-1:0]     i_base,
    input  wire logic                          i_ack,
    output tvn_pkg::t_core_stat                o_stat,
    output logic [tvn_pkg::INT_W-1:0]          o_int,
    output logic [tvn_pkg::COORD_W-1:0]        o_x,
    output logic [tvn_pkg::COORD_W-1:0]        o_y
);
    localparam int DEPTH  = NOISE_WIDTH * NOISE_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = $clog2(NOISE_WIDTH);
    localparam int YW     = $clog2(NOISE_HEIGHT);
    localparam int KW     = $clog2(MAX_OCTAVES + 1);
    localparam int CW     = tvn_pkg::COORD_W;
    localparam int NW     = tvn_pkg::NOISE_W;
    localparam int FW     = tvn_pkg::FRAC_W;
    localparam int SW     = tvn_pkg::SUM_W;
    localparam int NCOORD = 2 ** CW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_OCT  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_RDC  = 4'd5;
    localparam logic [3:0] S_RDD  = 4'd6;
    localparam logic [3:0] S_RDE  = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;
    localparam logic [3:0] S_VMUL = 4'd9;
    localparam logic [3:0] S_BLND = 4'd10;
    localparam logic [3:0] S_QEST = 4'd11;
    localparam logic [3:0] S_QMUL = 4'd12;
    localparam logic [3:0] S_ACC  = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    // Coordinate wrap tables
    logic [XW-1:0] x_mod [NCOORD];
    logic [YW-1:0] y_mod [NCOORD];
    for (genvar g = 0; g < NCOORD; g++) begin : g_mod
        assign x_mod[g] = XW'(g % NOISE_WIDTH);
        assign y_mod[g] = YW'(g % NOISE_HEIGHT);
    end

    logic [3:0]                r_state, n_state;
    logic [KW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_x, n_x, r_y, n_y;
    logic [XW-1:0]             r_x1, n_x1, r_x2, n_x2;
    logic [YW-1:0]             r_y1, n_y1, r_y2, n_y2;
    logic [FW-1:0]             r_fx, n_fx, r_fy, n_fy;
    logic [tvn_pkg::ZOOM_W-1:0] r_d, n_d;
    logic [NW-1:0]             r_na, n_na, r_nb, n_nb, r_nc, n_nc;
    logic signed [31:0]        r_prod1, n_prod1, r_prod2, n_prod2;
    logic signed [31:0]        r_r1, n_r1, r_r2, n_r2;
    logic signed [47:0]        r_prod3, n_prod3;
    logic [22:0]               r_v, n_v, r_q0, n_q0;
    logic [23:0]               r_qd, n_qd;
    logic [SW-1:0]             r_sum, n_sum;
    logic [tvn_pkg::INT_W-1:0] r_int, n_int;

    logic                      div_start, div_busy;
    logic [tvn_pkg::DVD_W-1:0] dvd_x, dvd_y;
    logic [tvn_pkg::QUO_W-1:0] quo_x, quo_y;

    logic          tab_we, tab_re;
    logic [AW-1:0] tab_waddr, tab_raddr;
    logic [NW-1:0] tab_rdata;

    tvn_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dvd_x   (dvd_x),
        .i_dvd_y   (dvd_y),
        .i_divisor (i_zoom),
        .o_busy    (div_busy),
        .o_quo_x   (quo_x),
        .o_quo_y   (quo_y)
    );

    tvn_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (i_noise),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = (r_state == S_FIN);
    assign o_stat.div_busy = div_busy;
    assign o_int           = r_int;
    assign o_x             = r_x;
    assign o_y             = r_y;

    // Arithmetic of each step
    logic [tvn_pkg::POW_W-1:0]   p3;
    logic [12:0]                 px, py;
    logic signed [16:0]          fx_s, fy_s;
    logic signed [15:0]          d_ab, d_cd;
    logic signed [32:0]          p1_full, p2_full;
    logic signed [31:0]          r_diff;
    logic signed [48:0]          p3_full;
    logic signed [47:0]          total;
    logic [47:0]                 vm_full;
    logic [30:0]                 qd_full;
    logic [23:0]                 rem;
    logic [9:0]                  turb;
    logic [10:0]                 pix_sum;
    logic [YW-1:0]               ra_y;
    logic [XW-1:0]               ra_x;

    assign p3      = tvn_pkg::POW3[tvn_pkg::OCT_IDX_W'(r_k)];
    assign px      = r_x * p3[tvn_pkg::ZOOM_W-1:0];
    assign py      = r_y * p3[tvn_pkg::ZOOM_W-1:0];
    assign dvd_x   = {px, {FW{1'b0}}};
    assign dvd_y   = {py, {FW{1'b0}}};
    assign fx_s    = $signed({1'b0, r_fx});
    assign fy_s    = $signed({1'b0, r_fy});
    assign d_ab    = $signed({1'b0, r_na}) - $signed({1'b0, r_nb});
    assign d_cd    = $signed({1'b0, r_nc}) - $signed({1'b0, tab_rdata});
    assign p1_full = fx_s * d_ab;
    assign p2_full = fx_s * d_cd;
    assign r_diff  = r_r1 - r_r2;
    assign p3_full = fy_s * r_diff;
    assign total   = $signed({1'b0, r_r2[30:0], {FW{1'b0}}}) + r_prod3;
    assign vm_full = r_v * tvn_pkg::RECIP[tvn_pkg::OCT_IDX_W'(r_k)];
    assign qd_full = r_q0 * r_d;
    assign rem     = {1'b0, r_v} - r_qd;
    assign turb    = r_sum[SW-1:FW];
    assign pix_sum = {3'b000, i_base} + {1'b0, turb};

    // Read address of the neighbor being fetched
    always_comb begin
        ra_y = r_y1;
        ra_x = r_x1;
        unique case (r_state)
            S_RDB:   ra_x = r_x2;
            S_RDC:   ra_y = r_y2;
            S_RDD: begin
                ra_y = r_y2;
                ra_x = r_x2;
            end
            default: ;
        endcase
    end

    assign tab_re    = (r_state == S_RDA) || (r_state == S_RDB) ||
                       (r_state == S_RDC) || (r_state == S_RDD);
    assign tab_raddr = AW'(ra_y) * AW'(NOISE_WIDTH) + AW'(ra_x);
    assign tab_we    = i_start && (i_req_type == tvn_pkg::REQ_LOAD);
    assign tab_waddr = AW'(y_mod[i_y]) * AW'(NOISE_WIDTH) + AW'(x_mod[i_x]);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_x     = r_x;
        n_y     = r_y;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_y1    = r_y1;
        n_y2    = r_y2;
        n_fx    = r_fx;
        n_fy    = r_fy;
        n_d     = r_d;
        n_na    = r_na;
        n_nb    = r_nb;
        n_nc    = r_nc;
        n_prod1 = r_prod1;
        n_prod2 = r_prod2;
        n_r1    = r_r1;
        n_r2    = r_r2;
        n_prod3 = r_prod3;
        n_v     = r_v;
        n_q0    = r_q0;
        n_qd    = r_qd;
        n_sum   = r_sum;
        n_int   = r_int;
        div_start = 1'b0;

        unique case (r_state)
            // Take a request; loads finish here
            S_IDLE: begin
                if (i_start && i_req_type == tvn_pkg::REQ_PIXEL) begin
                    n_x     = i_x;
                    n_y     = i_y;
                    n_k     = '0;
                    n_sum   = '0;
                    n_state = S_OCT;
                end
            end
            // Start the next octave or close the pixel
            S_OCT: begin
                if (r_k < KW'(MAX_OCTAVES) &&
                    p3 <= {{(tvn_pkg::POW_W-tvn_pkg::ZOOM_W){1'b0}}, i_zoom}) begin
                    div_start = 1'b1;
                    n_d       = p3[tvn_pkg::ZOOM_W-1:0];
                    n_state   = S_DIV;
                end else begin
                    n_int   = pix_sum[10:8] != 3'b000 ? tvn_pkg::INT_MAX : pix_sum[7:0];
                    n_state = S_FIN;
                end
            end
            // Wait for the sample position; split cell and fraction
            S_DIV: begin
                if (!div_busy) begin
                    n_x1    = x_mod[quo_x[tvn_pkg::QUO_W-1:FW]];
                    n_y1    = y_mod[quo_y[tvn_pkg::QUO_W-1:FW]];
                    n_x2    = (x_mod[quo_x[tvn_pkg::QUO_W-1:FW]] == '0) ?
                              XW'(NOISE_WIDTH - 1) : x_mod[quo_x[tvn_pkg::QUO_W-1:FW]] - 1'b1;
                    n_y2    = (y_mod[quo_y[tvn_pkg::QUO_W-1:FW]] == '0) ?
                              YW'(NOISE_HEIGHT - 1) : y_mod[quo_y[tvn_pkg::QUO_W-1:FW]] - 1'b1;
                    n_fx    = quo_x[FW-1:0];
                    n_fy    = quo_y[FW-1:0];
                    n_state = S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: begin
                n_na    = tab_rdata;
                n_state = S_RDC;
            end
            S_RDC: begin
                n_nb    = tab_rdata;
                n_state = S_RDD;
            end
            // Upper row interpolation product
            S_RDD: begin
                n_nc    = tab_rdata;
                n_prod1 = p1_full[31:0];
                n_state = S_RDE;
            end
            // Lower row product; keep the last neighbor
            S_RDE: begin
                n_na    = tab_rdata;
                n_prod2 = p2_full[31:0];
                n_state = S_SUM;
            end
            S_SUM: begin
                n_r1    = $signed({1'b0, r_nb, {FW{1'b0}}}) + r_prod1;
                n_r2    = $signed({1'b0, r_na, {FW{1'b0}}}) + r_prod2;
                n_state = S_VMUL;
            end
            S_VMUL: begin
                n_prod3 = p3_full[47:0];
                n_state = S_BLND;
            end
            // Blend in Q16, times 128
            S_BLND: begin
                n_v     = {total[46:31], 7'b0000000};
                n_state = S_QEST;
            end
            // Quotient estimate by reciprocal, then correct
            S_QEST: begin
                n_q0    = vm_full[46:tvn_pkg::RECIP_SH];
                n_state = S_QMUL;
            end
            S_QMUL: begin
                n_qd    = qd_full[23:0];
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum   = r_sum + SW'(r_q0) + SW'(rem >= {16'd0, r_d});
                n_k     = r_k + 1'b1;
                n_state = S_OCT;
            end
            // Hold the result until the output stage takes it
            S_FIN: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_x     <= n_x;
        r_y     <= n_y;
        r_x1    <= n_x1;
        r_x2    <= n_x2;
        r_y1    <= n_y1;
        r_y2    <= n_y2;
        r_fx    <= n_fx;
        r_fy    <= n_fy;
        r_d     <= n_d;
        r_na    <= n_na;
        r_nb    <= n_nb;
        r_nc    <= n_nc;
        r_prod1 <= n_prod1;
        r_prod2 <= n_prod2;
        r_r1    <= n_r1;
        r_r2    <= n_r2;
        r_prod3 <= n_prod3;
        r_v     <= n_v;
        r_q0    <= n_q0;
        r_qd    <= n_qd;
        r_sum   <= n_sum;
        r_int   <= n_int;
    end

endmodule
`default_nettype wire

>>> rtl/turbulence_value_noise.sv
`default_nettype none
// ---------------------------------------------------------------------------
// turbulence_value_noise
// Value-noise turbulence pixel generator over a wrapping noise table.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries requests. A load request (req_type 0) writes one noise
//   word into the table in the cycle it is taken and gives no result. A
//   pixel request (req_type 1) gives one result on o_res: base_offset plus
//   the turbulence at (x, y), saturated at 255, with the pixel coordinates.
//   Table entries must be loaded before a pixel reads them.
//   zoom_size (address 0) and base_offset (address 4) are written over APB
//   only while no request is in flight; the user must keep to this, as the
//   block does not enforce it. pready is always high.
//   A pixel runs one octave per k below MAX_OCTAVES with 3^k <= zoom.
//   Each octave runs the serial position divider, then four table reads
//   through the single read port and six multiply/add steps.
//   One request is worked on at a time.
//   The result sits in an output register, so the next request is taken
//   while o_res is stalled; a second finished pixel waits in the core.
//   Reset restores zoom_size 3 and base_offset 10; the table is not cleared.
// ---------------------------------------------------------------------------
module turbulence_value_noise #(
    parameter int NOISE_WIDTH  = 32,
    parameter int NOISE_HEIGHT = 32,
    parameter int MAX_OCTAVES  = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tvn_req_if.sink                            i_req,
    tvn_res_if.source                          o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tvn_pkg::APB_AW-1:0]    paddr,
    input  wire logic [tvn_pkg::APB_DW-1:0]    pwdata,
    output logic [tvn_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    logic [tvn_pkg::ZOOM_W-1:0]  r_zoom;
    logic [tvn_pkg::INT_W-1:0]   r_base;
    logic                        r_ov, n_ov;
    logic [tvn_pkg::INT_W-1:0]   r_oint;
    logic [tvn_pkg::COORD_W-1:0] r_ox, r_oy;

    tvn_pkg::t_core_stat          stat;
    logic [tvn_pkg::INT_W-1:0]   core_int;
    logic [tvn_pkg::COORD_W-1:0] core_x, core_y;
    logic                        req_take, out_load, apb_wr;

    assign pready   = 1'b1;
    assign apb_wr   = psel && penable && pwrite;
    assign req_take = i_req.valid && i_req.ready;
    assign out_load = stat.done && (!r_ov || o_res.ready);

    // Register read back
    assign prdata = (paddr[2] == tvn_pkg::REG_ZOOM) ?
                    tvn_pkg::APB_DW'(r_zoom) : tvn_pkg::APB_DW'(r_base);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom <= tvn_pkg::ZOOM_RST;
            r_base <= tvn_pkg::BASE_RST;
        end else if (apb_wr) begin
            unique case (paddr[2])
                tvn_pkg::REG_ZOOM: r_zoom <= pwdata[tvn_pkg::ZOOM_W-1:0];
                tvn_pkg::REG_BASE: r_base <= pwdata[tvn_pkg::INT_W-1:0];
                default: ;
            endcase
        end
    end

    tvn_core #(
        .NOISE_WIDTH  (NOISE_WIDTH),
        .NOISE_HEIGHT (NOISE_HEIGHT),
        .MAX_OCTAVES  (MAX_OCTAVES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (req_take),
        .i_req_type (i_req.req_type),
        .i_x        (i_req.x_coord),
        .i_y        (i_req.y_coord),
        .i_noise    (i_req.noise_value),
        .i_zoom     (r_zoom),
        .i_base     (r_base),
        .i_ack      (out_load),
        .o_stat     (stat),
        .o_int      (core_int),
        .o_x        (core_x),
        .o_y        (core_y)
    );

    assign i_req.ready = stat.idle;

    // Output register: load a finished pixel, drop it once taken
    always_comb begin
        priority if (out_load) begin
            n_ov = 1'b1;
        end else if (o_res.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oint <= core_int;
            r_ox   <= core_x;
            r_oy   <= core_y;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.intensity = r_oint;
    assign o_res.x_out     = r_ox;
    assign o_res.y_out     = r_oy;

    // A load request leaves the core idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take && i_req.req_type == tvn_pkg::REQ_LOAD |=> stat.idle)
        else $error("load request left the core busy");

    // The divider is free whenever a request can be taken
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !stat.div_busy)
        else $error("divider busy while core idle");

    // A finished pixel stays in the core until the output stage takes it
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done && !out_load |=> stat.done)
        else $error("finished pixel dropped before output");

endmodule
`default_nettype wire

>>> tb/tb_turbulence_value_noise.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_turbulence_value_noise
// Fills the noise table, then runs a series of register settings, each with
// random load and pixel requests under one of four idling patterns, plus
// directed ones at reset and for saturation. Each pixel is predicted at
// acceptance, checked field by field against the block's results in order.
// ---------------------------------------------------------------------------
module tb_turbulence_value_noise;

    localparam int TBL_W   = 32;
    localparam int TBL_H   = 32;
    localparam int OCT_MAX = 6;
    localparam int PER_PIX = 34 * OCT_MAX + 3;

    typedef struct {
        logic [tvn_pkg::INT_W-1:0]   intensity;
        logic [tvn_pkg::COORD_W-1:0] x;
        logic [tvn_pkg::COORD_W-1:0] y;
    } t_pixel;

    // Predicts pixel intensities and holds those still owed by the block
    class pixel_scoreboard;
        logic [tvn_pkg::NOISE_W-1:0] noise [TBL_W*TBL_H];
        int unsigned        zoom;
        int unsigned        base;
        t_pixel             pending [$];
        int                 mismatches;

        function new();
            zoom = int'(tvn_pkg::ZOOM_RST);
            base = int'(tvn_pkg::BASE_RST);
            mismatches = 0;
            foreach (noise[i]) noise[i] = '0;
        endfunction

        function longint unsigned entry(int unsigned row, int unsigned col);
            return longint'(noise[(row % TBL_H) * TBL_W + (col % TBL_W)]);
        endfunction

        function longint unsigned sample(int unsigned x, int unsigned y, int unsigned p3);
            longint unsigned ux, uy, fx, fy, gx, gy, acc;
            int unsigned x1, y1, x2, y2;
            ux = (longint'(x) * p3 * 65536) / zoom;
            uy = (longint'(y) * p3 * 65536) / zoom;
            fx = ux & 16'hFFFF;
            fy = uy & 16'hFFFF;
            gx = 65536 - fx;
            gy = 65536 - fy;
            x1 = (ux >> 16) % TBL_W;
            y1 = (uy >> 16) % TBL_H;
            x2 = (x1 + TBL_W - 1) % TBL_W;
            y2 = (y1 + TBL_H - 1) % TBL_H;
            acc = fx * fy * entry(y1, x1) + gx * fy * entry(y1, x2)
                + fx * gy * entry(y2, x1) + gx * gy * entry(y2, x2);
            return acc >> 31;
        endfunction

        // Note an accepted request: load the table or queue the pixel
        function void note(logic t, int unsigned x, int unsigned y, int unsigned nv);
            longint unsigned sum;
            int unsigned p3, v;
            t_pixel px;
            if (t == tvn_pkg::REQ_LOAD) begin
                noise[(y % TBL_H) * TBL_W + (x % TBL_W)] = tvn_pkg::NOISE_W'(nv);
                return;
            end
            sum = 0;
            p3 = 1;
            if (zoom != 0) begin
                for (int k = 0; k < OCT_MAX; k++) begin
                    if (zoom < p3) break;
                    sum += (sample(x, y, p3) * 128) / p3;
                    p3 *= 3;
                end
            end
            v = base + int'(sum >> 16);
            px.intensity = (v > 255) ? tvn_pkg::INT_MAX : tvn_pkg::INT_W'(v);
            px.x = tvn_pkg::COORD_W'(x);
            px.y = tvn_pkg::COORD_W'(y);
            pending.push_back(px);
        endfunction

        function void check(logic [tvn_pkg::INT_W-1:0] i, logic [tvn_pkg::COORD_W-1:0] x,
                            logic [tvn_pkg::COORD_W-1:0] y);
            t_pixel e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: intensity %0d at (%0d,%0d)", i, x, y);
                return;
            end
            e = pending.pop_front();
            if (e.intensity !== i || e.x !== x || e.y !== y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected %0d at (%0d,%0d), got %0d at (%0d,%0d)",
                             e.intensity, e.x, e.y, i, x, y);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [tvn_pkg::APB_AW-1:0] paddr = '0;
    logic [tvn_pkg::APB_DW-1:0] pwdata = '0;
    logic [tvn_pkg::APB_DW-1:0] prdata;
    logic pready;

    tvn_req_if req_ch ();
    tvn_res_if res_ch ();

    pixel_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  holdoff_cycles = 0;

    turbulence_value_noise uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = tvn_pkg::REQ_LOAD;
        req_ch.x_coord = '0;
        req_ch.y_coord = '0;
        req_ch.noise_value = '0;
        res_ch.ready = 1'b0;
    end

    // Stall the result side at random, or hold it off for a counted stretch
    always @(posedge i_clk) begin
        if (holdoff_cycles > 0) begin
            holdoff_cycles <= holdoff_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted pixel
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check(res_ch.intensity, res_ch.x_out, res_ch.y_out);
    end

    task automatic send(logic t, int unsigned x, int unsigned y, int unsigned nv);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= t;
        req_ch.x_coord <= tvn_pkg::COORD_W'(x);
        req_ch.y_coord <= tvn_pkg::COORD_W'(y);
        req_ch.noise_value <= tvn_pkg::NOISE_W'(nv);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note(t, x, y, nv);
    endtask

    // Drop valid and hold until every pixel has come back, plus settle time
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PER_PIX + 20) @(posedge i_clk);
    endtask

    task automatic reg_write(int idx, int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tvn_pkg::APB_AW'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == int'(tvn_pkg::REG_ZOOM)) sb.zoom = value & 8'hFF;
        else if (idx == int'(tvn_pkg::REG_BASE)) sb.base = value & 8'hFF;
    endtask

    initial begin
        int zooms [7] = '{3, 1, 255, 81, 2, 27, 243};
        int bases [7] = '{10, 0, 255, 200, 128, 37, 0};
        int unsigned rx, ry;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the table so that no pixel reads an unwritten entry
        for (int c = 0; c < TBL_W * TBL_H; c++) begin
            if (c == 0) send(tvn_pkg::REQ_LOAD, 0, 0, 0);
            else if (c == TBL_W * TBL_H - 1) send(tvn_pkg::REQ_LOAD, 31, 31, 15'h7FFF);
            else send(tvn_pkg::REQ_LOAD, c % TBL_W, c / TBL_W, $urandom_range(32767));
        end
        // Reset settings: corners and wrap at the low edge
        send(tvn_pkg::REQ_PIXEL, 0, 0, 0);
        send(tvn_pkg::REQ_PIXEL, 31, 31, 15'h7FFF);
        send(tvn_pkg::REQ_PIXEL, 0, 31, 0);
        send(tvn_pkg::REQ_PIXEL, 31, 0, 0);
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                reg_write(int'(tvn_pkg::REG_ZOOM), zooms[p]);
                reg_write(int'(tvn_pkg::REG_BASE), bases[p]);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            // Full-scale entries around the corner for the saturating phase
            if (p == 2) begin
                send(tvn_pkg::REQ_LOAD, 0, 0, 15'h7FFF);
                send(tvn_pkg::REQ_LOAD, 31, 0, 15'h7FFF);
                send(tvn_pkg::REQ_LOAD, 0, 31, 15'h7FFF);
                send(tvn_pkg::REQ_PIXEL, 0, 0, 0);
                send(tvn_pkg::REQ_PIXEL, 31, 31, 0);
                holdoff_cycles = 1500;
            end
            for (int n = 0; n < 75; n++) begin
                rx = $urandom_range(31);
                ry = $urandom_range(31);
                if ($urandom_range(99) < 70)
                    send(tvn_pkg::REQ_PIXEL, rx, ry, $urandom_range(32767));
                else
                    send(tvn_pkg::REQ_LOAD, rx, ry, $urandom_range(32767));
                // Pause mid-phase until the block has returned everything
                if (p == 4 && n == 30) drain();
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("turbulence_value_noise regression: pass");
        else
            $display("turbulence_value_noise regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("turbulence_value_noise regression: fail");
        $finish;
    end
endmodule

>>> filelist.f
rtl/tvn_pkg.sv
rtl/tvn_stream_if.sv
rtl/tvn_div.sv
rtl/tvn_table.sv
rtl/tvn_core.sv
rtl/turbulence_value_noise.sv
tb/tb_turbulence_value_noise.sv
